// ===== sv/mmh3_pkg.sv =====
// Shared constants and types for the MurmurHash3 x86_32 hash unit.
`default_nettype none
package mmh3_pkg;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] MIX_M5  = 32'd5;
  localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

  // Constant operand chosen for the shared multiplier
  typedef enum logic [2:0] {
    MUL_C1,
    MUL_C2,
    MUL_5,
    MUL_F1,
    MUL_F2
  } mul_sel_t;

  // Result handoff from the sequencer to the output register
  typedef struct packed {
    logic        valid;
    logic [31:0] hash;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/murmur3_32bit_hash_unit.sv =====
// Top level of the MurmurHash3 x86_32 byte-stream hash unit.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | data_byte, has_byte, last
//  out_    | output    | out_valid/out_stall| hash
//  cfg_    | input     | cfg_valid/cfg_ready| seed (32 bit)
//
// A byte that does not close a 4-byte block is taken in the idle state; a
// closing byte adds the block mix B1, B2, B3 (three passes through the one
// shared multiplier). A last word adds the tail mix T1, T2 (when 1-3 bytes are
// pending), the finalizer F0, F1, F2 and the hand-off to the output register.
// Synchronous active-low reset; seed resets to 0. A stalled result sits in the
// output register while the next message is already being taken.
`default_nettype none
module murmur3_32bit_hash_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_hash,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_seed
);

  logic [31:0]     seed_r;
  logic            out_valid_r;
  logic [31:0]     out_hash_r;
  logic            item_ready;
  logic            res_ready;
  mmh3_pkg::res_t  res;

  assign cfg_ready = 1'b1;
  assign in_stall  = !item_ready;
  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_seed;
    end
  end

  mmh3_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed_r),
    .item_valid (in_valid),
    .item_ready (item_ready),
    .data_byte  (in_data_byte),
    .has_byte   (in_has_byte),
    .last       (in_last),
    .res        (res),
    .res_ready  (res_ready)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
      if (res.valid) begin
        out_hash_r <= res.hash;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/mmh3_mul.sv =====
// Shared 32x32 multiplier, low word, against one of the hash constants.
`default_nettype none
module mmh3_mul (
  input  wire logic [31:0]       a,
  input  wire mmh3_pkg::mul_sel_t sel,
  output logic [31:0]            prod
);

  logic [31:0] k;

  always_comb begin
    unique case (sel)
      mmh3_pkg::MUL_C1: k = mmh3_pkg::MIX_C1;
      mmh3_pkg::MUL_C2: k = mmh3_pkg::MIX_C2;
      mmh3_pkg::MUL_5:  k = mmh3_pkg::MIX_M5;
      mmh3_pkg::MUL_F1: k = mmh3_pkg::FIN_M1;
      mmh3_pkg::MUL_F2: k = mmh3_pkg::FIN_M2;
      default:          k = mmh3_pkg::MIX_C1;
    endcase
  end

  // modulo 2^32 product
  assign prod = a * k;

endmodule
`default_nettype wire

// ===== sv/mmh3_seq.sv =====
// Sequencer and datapath: byte gathering, block mix, tail mix and finalizer steps.
`default_nettype none
module mmh3_seq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] seed,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        last,
  output mmh3_pkg::res_t   res,
  input  wire logic        res_ready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_B1,
    S_B2,
    S_B3,
    S_T1,
    S_T2,
    S_F0,
    S_F1,
    S_F2,
    S_EMIT
  } state_t;

  state_t      state_r;
  logic [31:0] hash_r;
  logic [31:0] acc_r;
  logic [31:0] blk_r;
  logic [1:0]  pos_r;
  logic [31:0] cnt_r;
  logic        started_r;
  logic        last_r;

  mmh3_pkg::mul_sel_t mul_sel;
  logic [31:0] prod;
  logic [31:0] base;
  logic [31:0] new_blk;
  logic [31:0] mix_h;

  mmh3_mul u_mul (
    .a    (acc_r),
    .sel  (mul_sel),
    .prod (prod)
  );

  always_comb begin
    unique case (state_r)
      S_B1, S_T1: mul_sel = mmh3_pkg::MUL_C1;
      S_B2, S_T2: mul_sel = mmh3_pkg::MUL_C2;
      S_B3:       mul_sel = mmh3_pkg::MUL_5;
      S_F1:       mul_sel = mmh3_pkg::MUL_F1;
      S_F2:       mul_sel = mmh3_pkg::MUL_F2;
      default:    mul_sel = mmh3_pkg::MUL_C1;
    endcase
  end

  // first byte of a message picks up the seed
  assign base    = started_r ? hash_r : seed;
  assign new_blk = blk_r | ({24'd0, data_byte} << {pos_r, 3'b000});
  assign mix_h   = hash_r ^ prod;

  assign item_ready = (state_r == S_IDLE);
  assign res.valid  = (state_r == S_EMIT);
  assign res.hash   = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      blk_r     <= '0;
      pos_r     <= '0;
      cnt_r     <= '0;
      started_r <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            hash_r <= base;
            last_r <= last;
            if (has_byte) begin
              started_r <= 1'b1;
              pos_r     <= pos_r + 2'd1;
              cnt_r     <= cnt_r + 32'd1;
              if (pos_r == 2'd3) begin
                acc_r   <= new_blk;
                blk_r   <= '0;
                state_r <= S_B1;
              end else begin
                blk_r <= new_blk;
                if (last) begin
                  acc_r   <= new_blk;
                  state_r <= S_T1;
                end
              end
            end else if (last) begin
              if (pos_r != 2'd0) begin
                acc_r   <= blk_r;
                state_r <= S_T1;
              end else begin
                state_r <= S_F0;
              end
            end
          end
        end
        S_B1: begin
          acc_r   <= {prod[16:0], prod[31:17]};
          state_r <= S_B2;
        end
        S_B2: begin
          acc_r   <= {mix_h[18:0], mix_h[31:19]};
          state_r <= S_B3;
        end
        S_B3: begin
          hash_r  <= prod + mmh3_pkg::MIX_ADD;
          state_r <= last_r ? S_F0 : S_IDLE;
        end
        S_T1: begin
          acc_r   <= {prod[16:0], prod[31:17]};
          state_r <= S_T2;
        end
        S_T2: begin
          hash_r  <= mix_h;
          state_r <= S_F0;
        end
        S_F0: begin
          acc_r   <= (hash_r ^ cnt_r) ^ ((hash_r ^ cnt_r) >> 16);
          state_r <= S_F1;
        end
        S_F1: begin
          acc_r   <= prod ^ (prod >> 13);
          state_r <= S_F2;
        end
        S_F2: begin
          acc_r   <= prod ^ (prod >> 16);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            blk_r     <= '0;
            pos_r     <= '0;
            cnt_r     <= '0;
            started_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the MurmurHash3 x86_32 byte-stream hash unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;   // long output hold-off
  localparam int WATCHDOG     = 5000;  // cycles without any word moving
  localparam int RAND_ITEMS   = 780;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_hash;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_seed;

  // test control
  logic        calm;       // no gaps and no random stalls while set
  logic        hold_tog;   // each toggle starts one long output hold-off
  logic        hold_seen;

  // hash model state
  logic [31:0] seed_reg;
  logic [31:0] acc_hash;
  logic [31:0] part_word;
  logic [1:0]  byte_pos;
  logic [31:0] msg_len;
  logic        msg_started;
  logic [31:0] pending_hashes[$];

  int n_items, n_msgs, n_seeds, n_errors, n_checked;
  int idle_cycles, stall_left, hold_left;

  murmur3_32bit_hash_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hash     (out_hash),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_seed     (cfg_seed)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] scramble_block(logic [31:0] k);
    logic [31:0] t;
    t = k * mmh3_pkg::MIX_C1;
    t = rotl32(t, 15);
    t = t * mmh3_pkg::MIX_C2;
    return t;
  endfunction

  function automatic logic [31:0] fmix32(logic [31:0] v);
    logic [31:0] h;
    h = v ^ (v >> 16);
    h = h * mmh3_pkg::FIN_M1;
    h = h ^ (h >> 13);
    h = h * mmh3_pkg::FIN_M2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Advance the hash state by one accepted word; queue the hash on last.
  task automatic absorb_word(input logic [7:0] b, input logic hb, input logic lst);
    logic [31:0] h;
    if (hb) begin
      if (!msg_started) begin
        acc_hash = seed_reg;
        msg_started = 1'b1;
      end
      part_word = part_word | ({24'h0, b} << (8 * byte_pos));
      byte_pos = byte_pos + 2'd1;
      msg_len = msg_len + 32'd1;
      if (byte_pos == 2'd0) begin
        h = acc_hash ^ scramble_block(part_word);
        h = rotl32(h, 13);
        acc_hash = h * mmh3_pkg::MIX_M5 + mmh3_pkg::MIX_ADD;
        part_word = '0;
      end
    end
    if (lst) begin
      h = msg_started ? acc_hash : seed_reg;
      if (byte_pos != 2'd0) h = h ^ scramble_block(part_word);
      h = h ^ msg_len;
      pending_hashes.push_back(fmix32(h));
      acc_hash = seed_reg;
      part_word = '0;
      byte_pos = '0;
      msg_len = '0;
      msg_started = 1'b0;
      n_msgs++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one word and hold it until accepted; valid stays high on return.
  task automatic send_word(input logic [7:0] b, input logic hb, input logic lst);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_has_byte  <= hb;
    in_last      <= lst;
    do @(posedge clk); while (in_stall !== 1'b0);
    absorb_word(b, hb, lst);
    if (hb || lst) n_items++;
  endtask

  // Message of len bytes; the end mark rides on the last byte or on its own word.
  task automatic send_message(input int len, input bit end_apart, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_apart);
    end
    if (len == 0 || end_apart) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    wait_idle();
    cfg_seed  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    seed_reg = v;
    n_seeds++;
  endtask

  task automatic test_directed();
    // reset seed of zero: empty message, ignored word, short messages
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h5a, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    write_seed(32'hffffffff);
    send_word(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 4; i++) send_word(8'hff, 1'b1, i == 3);
    for (int i = 0; i < 5; i++) send_word(8'h00, 1'b1, i == 4);
    send_word(8'ha5, 1'b1, 1'b0);
    send_word(8'h3c, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_seed_midstream();
    write_seed(32'h0);
    send_word(8'h12, 1'b1, 1'b0);
    send_word(8'h34, 1'b1, 1'b0);
    write_seed(32'hdeadbeef);   // current message keeps the old seed
    send_word(8'h56, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random();
    int len, r, phase_start;
    for (int p = 0; p < 4; p++) begin
      write_seed(p == 0 ? 32'h0 : p == 1 ? 32'hffffffff : $urandom());
      phase_start = n_items;
      while (n_items - phase_start < RAND_ITEMS / 4) begin
        if ($urandom_range(0, 14) == 0) calm <= ~calm;
        r = $urandom_range(0, 99);
        len = r < 70 ? $urandom_range(0, 8) : r < 95 ? $urandom_range(9, 20)
                                                     : $urandom_range(21, 64);
        send_message(len, $urandom_range(0, 4) == 0, 5);
      end
    end
    calm <= 1'b0;
  endtask

  task automatic test_backpressure();
    write_seed($urandom());
    calm <= 1'b1;
    hold_tog <= ~hold_tog;
    for (int i = 0; i < 30; i++) send_message($urandom_range(1, 3), 1'b0, 0);
    calm <= 1'b0;
  endtask

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else if (hold_seen != hold_tog) begin
      hold_seen <= hold_tog;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= hold_left != 0;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_checked++;
      if (pending_hashes.size() == 0) begin
        if (n_errors < 10) $display("ERROR: unexpected hash %08h", out_hash);
        n_errors++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_hash !== want) begin
          if (n_errors < 10)
            $display("ERROR: hash %0d expected %08h got %08h", n_checked, want, out_hash);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG);
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_has_byte  = 1'b0;
    in_last      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_seed     = '0;
    calm         = 1'b0;
    hold_tog     = 1'b0;
    seed_reg     = '0;
    acc_hash     = '0;
    part_word    = '0;
    byte_pos     = '0;
    msg_len      = '0;
    msg_started  = 1'b0;
    idle_cycles  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_seed_midstream();
    test_random();
    test_backpressure();
    wait_idle();

    $display("Hashed %0d messages from %0d words under %0d seed writes;", n_msgs, n_items,
             n_seeds);
    $display("random gaps and stalls plus one %0d-cycle output hold-off.", HOLD_CYCLES);
    if (n_errors == 0 && pending_hashes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d hashes missing", n_errors, pending_hashes.size());
      $display("testbench failed");
    end
    $finish;
  end

endmodule
